// ===== sv/ookrl_pkg.sv =====
// Shared types and constants for the OOK run-length symbol decoder.
package ookrl_pkg;

   // Configuration register indexes
   localparam logic [2:0] RegNoiseLowLimit     = 3'd0;
   localparam logic [2:0] RegHeaderLowThresh   = 3'd1;
   localparam logic [2:0] RegDoubleHighThresh  = 3'd2;
   localparam logic [2:0] RegDoubleLowThresh   = 3'd3;
   localparam logic [2:0] RegSymbolsPerFrame   = 3'd4;

   // Configuration reset values
   localparam logic [7:0] NoiseLowLimitReset    = 8'd5;
   localparam logic [7:0] HeaderLowThreshReset  = 8'd20;
   localparam logic [7:0] DoubleHighThreshReset = 8'd12;
   localparam logic [7:0] DoubleLowThreshReset  = 8'd12;
   localparam logic [9:0] SymbolsPerFrameReset  = 10'd128;

   // Result kinds
   localparam logic KindSymbol  = 1'b0;
   localparam logic KindFailure = 1'b1;

   localparam logic [7:0] RunMax = 8'hFF;

   // Most results one sample can cause
   localparam int MaxResults = 3;

   typedef struct packed {
      logic       kind;
      logic       symbol;
      logic [9:0] symbol_index;
      logic       frame_done;
   } rsp_rec_type;

endpackage

// ===== sv/ook_run_length_symbol_decoder.sv =====
// OOK run-length symbol decoder: light samples in, decoded symbols out.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata: sample; tuser: first_sample;
//           |     |                       | tlast: last_sample
//   rsp     | out | rsp_tvalid/rsp_tready | tdata: symbol, symbol_index, frame_done;
//           |     |                       | tuser: kind; tlast: run_end
//   csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// A sample is decoded in the cycle it is transferred; its results (zero to three)
// are held in a result buffer and leave one per cycle while rsp_tready is high, so
// a sample causing at most one result sustains one sample per cycle when the
// output does not stall. The next sample is taken in the cycle the final
// result of the buffer transfers. Reset is synchronous and clears decoder state,
// the buffer and the registers to their defaults. csr_ready is always high.
module ook_run_length_symbol_decoder
   import ookrl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] sample, [7:1] zero
   input  logic        req_tuser,   // [0] first_sample
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] symbol, [10:1] symbol_index, [11] frame_done,
                                    // [15:12] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,   // run_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data
);

   // configuration
   logic [7:0] noise_ff, header_ff, dbl_high_ff, dbl_low_ff;
   logic [9:0] spf_ff;

   // decoder state
   logic [7:0] high_run_ff, high_run_in;
   logic [7:0] low_run_ff, low_run_in;
   logic [9:0] count_ff, count_in;
   logic       started_ff, started_in;
   logic       expect_ff, expect_in;
   logic       fin_ff, fin_in;

   // result buffer
   rsp_rec_type rec_ff [MaxResults];
   rsp_rec_type rec_in [MaxResults];
   logic [1:0]  total_ff, total_in;
   logic [1:0]  pos_ff;
   rsp_rec_type cur_rec;

   logic req_xfer, rsp_xfer, last_xfer;

   assign csr_ready = 1'b1;

   assign rsp_tvalid = (total_ff != 2'd0);
   assign rsp_tlast  = (pos_ff == total_ff - 2'd1);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign last_xfer  = rsp_xfer && rsp_tlast;
   assign req_tready = !rsp_tvalid || last_xfer;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      unique case (pos_ff)
         2'd0:    cur_rec = rec_ff[0];
         2'd1:    cur_rec = rec_ff[1];
         2'd2:    cur_rec = rec_ff[2];
         default: cur_rec = rec_ff[0];
      endcase
   end

   assign rsp_tuser = cur_rec.kind;
   assign rsp_tdata = {4'b0, cur_rec.frame_done, cur_rec.symbol_index, cur_rec.symbol};

   // decode one sample against the current state
   always_comb begin
      logic [9:0]  len;
      logic [9:0]  base;
      logic [10:0] base_p1;
      logic [1:0]  nsym;
      logic        symv;
      logic        fail;
      logic [10:0] idx_k;

      len  = (spf_ff == 10'd0) ? 10'd1 : spf_ff;
      nsym = 2'd0;
      symv = 1'b0;
      fail = 1'b0;

      high_run_in = req_tuser ? 8'd0  : high_run_ff;
      low_run_in  = req_tuser ? 8'd0  : low_run_ff;
      count_in    = req_tuser ? 10'd0 : count_ff;
      started_in  = req_tuser ? 1'b0  : started_ff;
      expect_in   = req_tuser ? 1'b0  : expect_ff;
      fin_in      = req_tuser ? 1'b0  : fin_ff;

      base    = count_in;
      base_p1 = {1'b0, base} + 11'd1;

      if (!fin_in) begin
         if (req_tdata[0]) begin
            if (high_run_in != RunMax) high_run_in = high_run_in + 8'd1;
         end else begin
            if (low_run_in != RunMax) low_run_in = low_run_in + 8'd1;
         end

         if (high_run_in != 8'd0 && low_run_in != 8'd0) begin
            if (!started_in) begin
               if (low_run_in <= noise_ff) begin
                  // drop the spike, keep counting the low run
                  high_run_in = 8'd0;
               end else begin
                  started_in = 1'b1;
                  if (low_run_in >= header_ff) nsym = 2'd1;
                  low_run_in = 8'd0;
                  expect_in  = 1'b1;
               end
            end else if (base < len) begin
               if (expect_in) begin
                  symv = 1'b1;
                  nsym = (high_run_in >= dbl_high_ff && base_p1 < {1'b0, len}) ? 2'd2 : 2'd1;
                  high_run_in = 8'd0;
                  expect_in   = 1'b0;
               end else begin
                  symv = 1'b0;
                  nsym = (low_run_in >= dbl_low_ff && base_p1 < {1'b0, len}) ? 2'd2 : 2'd1;
                  low_run_in = 8'd0;
                  expect_in  = 1'b1;
               end
            end
         end

         count_in = base + {8'b0, nsym};

         priority if (started_in && count_in >= len) begin
            fin_in = 1'b1;
         end else if (req_tlast) begin
            fail   = 1'b1;
            fin_in = 1'b1;
         end else begin
            fail = 1'b0;
         end
      end

      total_in = nsym + {1'b0, fail};

      for (int k = 0; k < MaxResults; k++) begin
         idx_k = {1'b0, base} + 11'(k);
         if (2'(k) < nsym) begin
            rec_in[k].kind         = KindSymbol;
            rec_in[k].symbol       = symv;
            rec_in[k].symbol_index = idx_k[9:0];
            rec_in[k].frame_done   = (idx_k + 11'd1 >= {1'b0, len});
         end else begin
            rec_in[k].kind         = KindFailure;
            rec_in[k].symbol       = 1'b0;
            rec_in[k].symbol_index = count_in;
            rec_in[k].frame_done   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff    <= NoiseLowLimitReset;
         header_ff   <= HeaderLowThreshReset;
         dbl_high_ff <= DoubleHighThreshReset;
         dbl_low_ff  <= DoubleLowThreshReset;
         spf_ff      <= SymbolsPerFrameReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegNoiseLowLimit:    noise_ff    <= csr_data[7:0];
            RegHeaderLowThresh:  header_ff   <= csr_data[7:0];
            RegDoubleHighThresh: dbl_high_ff <= csr_data[7:0];
            RegDoubleLowThresh:  dbl_low_ff  <= csr_data[7:0];
            RegSymbolsPerFrame:  spf_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_run_ff <= 8'd0;
         low_run_ff  <= 8'd0;
         count_ff    <= 10'd0;
         started_ff  <= 1'b0;
         expect_ff   <= 1'b0;
         fin_ff      <= 1'b0;
      end else if (req_xfer) begin
         high_run_ff <= high_run_in;
         low_run_ff  <= low_run_in;
         count_ff    <= count_in;
         started_ff  <= started_in;
         expect_ff   <= expect_in;
         fin_ff      <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 2'd0;
         pos_ff   <= 2'd0;
      end else if (req_xfer) begin
         // load results of the new sample; none leaves the buffer empty
         total_ff <= total_in;
         pos_ff   <= 2'd0;
      end else if (last_xfer) begin
         total_ff <= 2'd0;
         pos_ff   <= 2'd0;
      end else if (rsp_xfer) begin
         pos_ff <= pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int k = 0; k < MaxResults; k++) begin
            rec_ff[k] <= rec_in[k];
         end
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pos_ff < total_ff)
      else $error("result pointer beyond buffered count");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && rsp_tvalid) |-> last_xfer)
      else $error("sample taken while results still pending");

   a_failure_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KindFailure) |-> rsp_tlast)
      else $error("failure result not last of its sample");

   a_done_finishes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KindSymbol && rsp_tdata[11]) |-> (fin_ff && rsp_tlast))
      else $error("frame completed without finishing decoder");

endmodule
